// ===== hw/rtl/imu_angle_frame_unwrapper_macros.svh =====
// assertion macros for the imu angle frame unwrapper
// used by modules that check their own state; expects clk and rst_n in scope
`ifndef IMU_ANGLE_FRAME_UNWRAPPER_MACROS_SVH
`define IMU_ANGLE_FRAME_UNWRAPPER_MACROS_SVH

// property that must hold at every edge out of reset
`define IAFU_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("imu_afu check failed");

// consequent must hold in the cycle after the antecedent
`define IAFU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imu_afu check failed");

`endif

// ===== hw/rtl/imu_afu_pkg.sv =====
// shared types and constants of the imu angle frame unwrapper
// no dependencies
package imu_afu_pkg;

    localparam int STATUS_W = 2;
    localparam int RAW_W    = 16;
    localparam int ANGLE_W  = 24;
    localparam int TURN_W   = 16;
    localparam int TOTAL_W  = 40;
    localparam int COUNT_W  = 32;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam int NUM_STORED = 8;

    localparam logic [STATUS_W-1:0] STAT_ANGLE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_SHORT      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_HEADER = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_OTHER      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_TYPE  = 1'd1;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h55;
    localparam logic [BYTE_W-1:0] TYPE_RESET   = 8'h53;

    localparam logic [ANGLE_W-1:0] DEG_SCALE = 24'd180;
    localparam logic [ANGLE_W-1:0] HIGH_MARK = 24'd10813440;
    localparam logic [ANGLE_W-1:0] LOW_MARK  = 24'd983040;
    localparam logic signed [TOTAL_W-1:0] FULL_TURN = 40'sd11796480;

    localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
    localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RAW_W-1:0]    raw_x;
        logic [RAW_W-1:0]    raw_y;
        logic [RAW_W-1:0]    raw_z;
    } frame_item_t;

endpackage

// ===== hw/rtl/imu_angle_frame_unwrapper.sv =====
// Takes one sensor byte per cycle and returns one result per burst end, in order.
// An input byte is taken every cycle unless the two-entry frame queue between the
// classifier and the angle unit is full, which only happens while results are
// held back by out_stall. A result reaches the output register from its burst-end
// byte via the queue, the scaling multiply, then unwrap and total. Sustained rate
// is one byte per cycle while out_stall is low, including back-to-back burst ends.
// top level; depends on imu_afu_pkg, imu_afu_front, imu_afu_queue, imu_afu_back
module imu_angle_frame_unwrapper #(
    parameter int FRAME_LEN = 11
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [imu_afu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [imu_afu_pkg::BYTE_W-1:0]           cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [imu_afu_pkg::BYTE_W-1:0]           data_byte,
    input  logic                                     burst_end,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [imu_afu_pkg::STATUS_W-1:0]         status,
    output logic signed [imu_afu_pkg::ANGLE_W-1:0]   roll_angle,
    output logic signed [imu_afu_pkg::ANGLE_W-1:0]   pitch_angle,
    output logic [imu_afu_pkg::ANGLE_W-1:0]          heading,
    output logic signed [imu_afu_pkg::TURN_W-1:0]    turn_count,
    output logic signed [imu_afu_pkg::TOTAL_W-1:0]   total_angle,
    output logic [imu_afu_pkg::COUNT_W-1:0]          header_frames,
    output logic [imu_afu_pkg::COUNT_W-1:0]          angle_frames
);

    logic                     q_full;
    logic                     q_push;
    logic                     q_pop;
    logic                     q_valid;
    imu_afu_pkg::frame_item_t push_item;
    imu_afu_pkg::frame_item_t pop_item;

    imu_afu_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .burst_end (burst_end),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    imu_afu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (pop_item)
    );

    imu_afu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .roll_angle    (roll_angle),
        .pitch_angle   (pitch_angle),
        .heading       (heading),
        .turn_count    (turn_count),
        .total_angle   (total_angle),
        .header_frames (header_frames),
        .angle_frames  (angle_frames)
    );

endmodule

// ===== hw/rtl/imu_afu_front.sv =====
// byte collector and frame classifier of the imu angle frame unwrapper
// depends on imu_afu_pkg; feeds classified frames into imu_afu_queue
module imu_afu_front #(
    parameter int FRAME_LEN = 11
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [imu_afu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imu_afu_pkg::BYTE_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [imu_afu_pkg::BYTE_W-1:0]         data_byte,
    input  logic                                   burst_end,
    input  logic                                   q_full,
    output logic                                   q_push,
    output imu_afu_pkg::frame_item_t               q_item
);

    localparam int IDX_W = $clog2(FRAME_LEN + 1);

    logic [imu_afu_pkg::BYTE_W-1:0] header_reg;
    logic [imu_afu_pkg::BYTE_W-1:0] type_reg;
    logic [IDX_W-1:0]               byte_index_reg;
    logic [IDX_W-1:0]               byte_index_next;
    logic [IDX_W-1:0]               idx_after;
    logic [imu_afu_pkg::BYTE_W-1:0] frame_reg [imu_afu_pkg::NUM_STORED];
    logic [imu_afu_pkg::BYTE_W-1:0] view [imu_afu_pkg::NUM_STORED];
    logic                           accept;
    logic                           below_len;
    logic                           store_en;

    assign in_stall  = q_full;
    assign accept    = in_valid && !in_stall;
    assign below_len = byte_index_reg < IDX_W'(FRAME_LEN);
    assign store_en  = accept && below_len && (byte_index_reg < IDX_W'(imu_afu_pkg::NUM_STORED));
    assign idx_after = below_len ? byte_index_reg + IDX_W'(1) : byte_index_reg;

    always_comb
    begin
        for (int k = 0; k < imu_afu_pkg::NUM_STORED; k++)
        begin
            if (store_en && (byte_index_reg[2:0] == 3'(k)))
            begin
                view[k] = data_byte;
            end
            else
            begin
                view[k] = frame_reg[k];
            end
        end
    end

    always_comb
    begin
        byte_index_next = byte_index_reg;
        if (accept)
        begin
            byte_index_next = burst_end ? '0 : idx_after;
        end
    end

    always_comb
    begin
        q_push       = accept && burst_end;
        q_item.raw_x = {view[3], view[2]};
        q_item.raw_y = {view[5], view[4]};
        q_item.raw_z = {view[7], view[6]};
        if (idx_after < IDX_W'(FRAME_LEN))
        begin
            q_item.status = imu_afu_pkg::STAT_SHORT;
        end
        else if (view[0] != header_reg)
        begin
            q_item.status = imu_afu_pkg::STAT_BAD_HEADER;
        end
        else if (view[1] != type_reg)
        begin
            q_item.status = imu_afu_pkg::STAT_OTHER;
        end
        else
        begin
            q_item.status = imu_afu_pkg::STAT_ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg     <= imu_afu_pkg::HEADER_RESET;
            type_reg       <= imu_afu_pkg::TYPE_RESET;
            byte_index_reg <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    imu_afu_pkg::CFG_HEADER_BYTE: header_reg <= cfg_data;
                    imu_afu_pkg::CFG_ANGLE_TYPE:  type_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // stored bytes, undefined until written
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            frame_reg[byte_index_reg[2:0]] <= data_byte;
        end
    end

endmodule

// ===== hw/rtl/imu_afu_queue.sv =====
// two-entry frame queue between classifier and angle unit
// depends on imu_afu_pkg
module imu_afu_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  imu_afu_pkg::frame_item_t   push_item,
    output logic                       full,
    input  logic                       pop,
    output logic                       pop_valid,
    output imu_afu_pkg::frame_item_t   pop_item
);

    localparam int AW = imu_afu_pkg::QUEUE_AW;

    imu_afu_pkg::frame_item_t mem [imu_afu_pkg::QUEUE_DEPTH];
    logic [AW-1:0]            wr_ptr_reg;
    logic [AW-1:0]            rd_ptr_reg;
    logic [AW:0]              count_reg;
    logic [AW:0]              count_next;
    logic                     do_push;
    logic                     do_pop;

    assign full      = count_reg == (AW+1)'(imu_afu_pkg::QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/imu_afu_back.sv =====
// angle scaling, heading unwrap, frame counters and output register
// depends on imu_afu_pkg and the assertion macro header
`include "imu_angle_frame_unwrapper_macros.svh"

module imu_afu_back (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          q_valid,
    input  imu_afu_pkg::frame_item_t                      q_item,
    output logic                                          q_pop,
    output logic                                          out_valid,
    input  logic                                          out_stall,
    output logic [imu_afu_pkg::STATUS_W-1:0]              status,
    output logic signed [imu_afu_pkg::ANGLE_W-1:0]        roll_angle,
    output logic signed [imu_afu_pkg::ANGLE_W-1:0]        pitch_angle,
    output logic [imu_afu_pkg::ANGLE_W-1:0]               heading,
    output logic signed [imu_afu_pkg::TURN_W-1:0]         turn_count,
    output logic signed [imu_afu_pkg::TOTAL_W-1:0]        total_angle,
    output logic [imu_afu_pkg::COUNT_W-1:0]               header_frames,
    output logic [imu_afu_pkg::COUNT_W-1:0]               angle_frames
);

    localparam int AW = imu_afu_pkg::ANGLE_W;
    localparam int TW = imu_afu_pkg::TOTAL_W;
    localparam int CW = imu_afu_pkg::COUNT_W;

    // scaling stage
    logic                                  a_valid_reg;
    logic [imu_afu_pkg::STATUS_W-1:0]      a_status_reg;
    logic signed [AW-1:0]                  a_roll_reg;
    logic signed [AW-1:0]                  a_pitch_reg;
    logic [AW-1:0]                         a_head_reg;
    logic [imu_afu_pkg::RAW_W-1:0]         z_offset;

    // unwrap state
    logic                                  seen_reg;
    logic                                  seen_next;
    logic [AW-1:0]                         prev_reg;
    logic [AW-1:0]                         prev_next;
    logic signed [imu_afu_pkg::TURN_W-1:0] rev_reg;
    logic signed [imu_afu_pkg::TURN_W-1:0] rev_next;
    logic signed [TW-1:0]                  base_reg;
    logic signed [TW-1:0]                  base_next;
    logic [CW-1:0]                         hdr_cnt_reg;
    logic [CW-1:0]                         hdr_cnt_next;
    logic [CW-1:0]                         ang_cnt_reg;
    logic [CW-1:0]                         ang_cnt_next;

    // output register
    logic                                  out_valid_reg;
    logic [imu_afu_pkg::STATUS_W-1:0]      out_status_reg;
    logic signed [AW-1:0]                  out_roll_reg;
    logic signed [AW-1:0]                  out_pitch_reg;
    logic [AW-1:0]                         out_head_reg;
    logic signed [TW-1:0]                  out_total_reg;

    logic                                  out_ready;
    logic                                  a_move;
    logic                                  is_angle;
    logic                                  hdr_ok;
    logic [AW-1:0]                         prev_eff;
    logic                                  turn_up;
    logic                                  turn_down;
    logic signed [TW-1:0]                  total_next;

    assign out_ready = !out_valid_reg || !out_stall;
    assign a_move    = a_valid_reg && out_ready;
    assign q_pop     = q_valid && (!a_valid_reg || out_ready);

    // raw + 32768 as unsigned is the raw value with its sign bit flipped
    assign z_offset = {~q_item.raw_z[imu_afu_pkg::RAW_W-1], q_item.raw_z[imu_afu_pkg::RAW_W-2:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (!a_valid_reg || out_ready)
        begin
            a_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_status_reg <= q_item.status;
            a_roll_reg   <= AW'(signed'(q_item.raw_x) * signed'(imu_afu_pkg::DEG_SCALE));
            a_pitch_reg  <= AW'(signed'(q_item.raw_y) * signed'(imu_afu_pkg::DEG_SCALE));
            a_head_reg   <= AW'(AW'(z_offset) * imu_afu_pkg::DEG_SCALE);
        end
    end

    always_comb
    begin
        is_angle  = a_status_reg == imu_afu_pkg::STAT_ANGLE;
        hdr_ok    = is_angle || (a_status_reg == imu_afu_pkg::STAT_OTHER);
        prev_eff  = seen_reg ? prev_reg : a_head_reg;
        turn_up   = (prev_eff > imu_afu_pkg::HIGH_MARK) && (a_head_reg < imu_afu_pkg::LOW_MARK);
        turn_down = (prev_eff < imu_afu_pkg::LOW_MARK) && (a_head_reg > imu_afu_pkg::HIGH_MARK);

        rev_next     = rev_reg;
        base_next    = base_reg;
        prev_next    = prev_reg;
        seen_next    = seen_reg;
        hdr_cnt_next = hdr_cnt_reg;
        ang_cnt_next = ang_cnt_reg;

        if (hdr_ok)
        begin
            hdr_cnt_next = hdr_cnt_reg + CW'(1);
        end
        if (is_angle)
        begin
            ang_cnt_next = ang_cnt_reg + CW'(1);
            seen_next    = 1'b1;
            prev_next    = a_head_reg;
            if (turn_up && (rev_reg != imu_afu_pkg::TURN_MAX))
            begin
                rev_next  = rev_reg + 16'sd1;
                base_next = base_reg + imu_afu_pkg::FULL_TURN;
            end
            else if (turn_down && (rev_reg != imu_afu_pkg::TURN_MIN))
            begin
                rev_next  = rev_reg - 16'sd1;
                base_next = base_reg - imu_afu_pkg::FULL_TURN;
            end
        end
        total_next = base_next + signed'(TW'(prev_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            seen_reg      <= 1'b0;
            prev_reg      <= '0;
            rev_reg       <= '0;
            base_reg      <= '0;
            hdr_cnt_reg   <= '0;
            ang_cnt_reg   <= '0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= a_valid_reg;
            end
            if (a_move)
            begin
                seen_reg    <= seen_next;
                prev_reg    <= prev_next;
                rev_reg     <= rev_next;
                base_reg    <= base_next;
                hdr_cnt_reg <= hdr_cnt_next;
                ang_cnt_reg <= ang_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            out_status_reg <= a_status_reg;
            out_roll_reg   <= is_angle ? a_roll_reg : '0;
            out_pitch_reg  <= is_angle ? a_pitch_reg : '0;
            out_head_reg   <= is_angle ? a_head_reg : '0;
            out_total_reg  <= total_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign roll_angle    = out_roll_reg;
    assign pitch_angle   = out_pitch_reg;
    assign heading       = out_head_reg;
    assign turn_count    = rev_reg;
    assign total_angle   = out_total_reg;
    assign header_frames = hdr_cnt_reg;
    assign angle_frames  = ang_cnt_reg;

    `IAFU_ASSERT_NEXT(a_rev_holds_idle, !a_move, rev_reg == $past(rev_reg))
    `IAFU_ASSERT(a_base_tracks_rev, base_reg == TW'(rev_reg) * imu_afu_pkg::FULL_TURN)
    `IAFU_ASSERT(a_non_angle_zero, (out_valid_reg && out_status_reg != imu_afu_pkg::STAT_ANGLE) |-> (out_roll_reg == '0 && out_pitch_reg == '0 && out_head_reg == '0))

endmodule
